@@ hw/rtl/pmcf_pkg.sv @@
// Package for the pH median calibrated filter core.
// Holds field widths, calibration constants, register indexes and default sizes.
// No dependencies.
package pmcf_pkg;

  // Default sizes
  localparam int DEF_BURST_SAMPLES = 9;
  localparam int DEF_WINDOW        = 8;

  // Field widths
  localparam int SAMPLE_W    = 12;
  localparam int PH_W        = 14;
  localparam int SLOPE_W     = 19;
  localparam int OFFSET_W    = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 19;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = DIFF_W + SLOPE_W;
  localparam int SHIFT       = 10;
  localparam int PH_SUM_W    = 24;

  // Calibration constants, 1/1024 pH units
  localparam logic [PH_W-1:0]            PH_SEVEN     = 14'd7168;
  localparam logic [PH_W-1:0]            PH_TOP       = 14'd14336;
  localparam logic signed [OFFSET_W-1:0] OFFSET_FLOOR = -15'sd512;

  // Register reset values
  localparam logic [SAMPLE_W-1:0]        RST_PH7_CODE = 12'd3102;
  localparam logic signed [SLOPE_W-1:0]  RST_SLOPE    = 19'sd5070;
  localparam logic signed [OFFSET_W-1:0] RST_OFFSET   = -15'sd512;
  localparam logic [PH_W-1:0]            RST_SAFE_MIN = 14'd6656;
  localparam logic [PH_W-1:0]            RST_SAFE_MAX = 14'd8704;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PH7_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_MAX = 3'd4;

endpackage

@@ hw/rtl/ph_median_calibrated_filter_core.sv @@
// Top level of the pH median calibrated filter core.
// Burst and ring memories, rank-select sequencer, calibration datapath.
// Depends on pmcf_pkg.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+----------------------
//  in      | s_tvalid s_tready s_tdata                 | s_tvalid & s_tready
//  out     | m_tvalid m_tready m_tdata m_tuser         | m_tvalid & m_tready
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | cfg_valid & cfg_ready
//
// A sample that does not close a burst is stored and the input stays ready. The
// sample that closes a burst starts a rank search over the burst memory: each
// candidate is read, all N entries are scanned through the single registered read
// port, and the counts are checked; then S_MUL and S_CONV run the calibration.
// Once the ring has wrapped a second search over the ring follows. Then S_OUT
// loads the output register, waiting while it is still full. Reset is synchronous
// and needs no clearing pass; the output register holds a result while the next
// samples keep arriving.
module ph_median_calibrated_filter_core
  import pmcf_pkg::*;
#(
  parameter int BURST_SAMPLES = DEF_BURST_SAMPLES,
  parameter int WINDOW        = DEF_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [11:0] adc_sample, [15:12] zero
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [13:0] ph_value, [15:14] zero
  output logic                  m_tuser,   // [0] in_safe_range
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NMAX = (BURST_SAMPLES > WINDOW) ? BURST_SAMPLES : WINDOW;
  localparam int AW   = $clog2(NMAX);
  localparam int CW   = $clog2(NMAX + 1);
  localparam int BW   = $clog2(BURST_SAMPLES);
  localparam int WW   = $clog2(WINDOW);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_CAND  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_CONV  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // Configuration registers
  logic [SAMPLE_W-1:0]        ph7_code;
  logic signed [SLOPE_W-1:0]  slope_per_code;
  logic signed [OFFSET_W-1:0] offset_corr;
  logic [PH_W-1:0]            safe_min;
  logic [PH_W-1:0]            safe_max;

  // Control state
  logic [2:0]    state;
  logic [BW-1:0] burst_count;
  logic [WW-1:0] window_index;
  logic          window_full;
  logic          phase_win;     // rank search runs over the ring, not the burst

  // Rank search registers
  logic [AW-1:0]   cand;
  logic [PH_W-1:0] cand_val;
  logic [CW-1:0]   issue;
  logic [CW-1:0]   done_cnt;
  logic [CW-1:0]   lt_cnt;
  logic [CW-1:0]   le_cnt;

  // Datapath registers
  logic [SAMPLE_W-1:0]      med;
  logic signed [PROD_W-1:0] product;
  logic [PH_W-1:0]          result;

  // Memories
  logic [SAMPLE_W-1:0] raw_mem [BURST_SAMPLES];
  logic [PH_W-1:0]     win_mem [WINDOW];
  logic [SAMPLE_W-1:0] raw_rdata;
  logic [PH_W-1:0]     win_rdata;

  // Combinational
  logic [AW-1:0]              rd_addr;
  logic [BW-1:0]              raw_raddr;
  logic [WW-1:0]              win_raddr;
  logic [PH_W-1:0]            rdata;
  logic [CW-1:0]              n_len;
  logic [CW-1:0]              k_rank;
  logic                       s_xfer;
  logic                       out_free;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-SHIFT-1:0] shifted;
  logic signed [OFFSET_W-1:0] off_eff;
  logic signed [PH_SUM_W-1:0] ph_sum;
  logic [PH_W-1:0]            ph_clamped;
  logic                       win_we;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_xfer    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign win_we    = (state == S_CONV);

  assign n_len  = phase_win ? CW'(WINDOW) : CW'(BURST_SAMPLES);
  assign k_rank = n_len >> 1;
  assign rdata  = phase_win ? win_rdata : {{(PH_W-SAMPLE_W){1'b0}}, raw_rdata};

  // Read address: candidate fetch in S_LOAD, scan stream in S_SCAN, zero otherwise
  always_comb begin
    rd_addr = '0;
    if (state == S_LOAD) begin
      rd_addr = cand;
    end else if (state == S_SCAN && issue < n_len) begin
      rd_addr = issue[AW-1:0];
    end
  end

  // Keep each memory's read address inside its own depth
  assign raw_raddr = ({1'b0, rd_addr} < (AW+1)'(BURST_SAMPLES)) ? rd_addr[BW-1:0] : '0;
  assign win_raddr = ({1'b0, rd_addr} < (AW+1)'(WINDOW)) ? rd_addr[WW-1:0] : '0;

  // Burst memory: one write per accepted sample, registered read
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      raw_mem[burst_count] <= s_tdata[SAMPLE_W-1:0];
    end
    raw_rdata <= raw_mem[raw_raddr];
  end

  // Ring memory: one write per burst result, registered read
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[window_index] <= ph_clamped;
    end
    win_rdata <= win_mem[win_raddr];
  end

  // Calibration: ph = 7168 + floor(diff*slope / 1024) + max(offset, -512), clamped
  assign diff    = $signed({1'b0, ph7_code}) - $signed({1'b0, med});
  assign shifted = product[PROD_W-1:SHIFT];   // arithmetic shift rounds toward minus infinity
  assign off_eff = (offset_corr < OFFSET_FLOOR) ? OFFSET_FLOOR : offset_corr;
  assign ph_sum  = $signed({{(PH_SUM_W-PH_W){1'b0}}, PH_SEVEN})
                 + PH_SUM_W'(shifted) + PH_SUM_W'(off_eff);

  always_comb begin
    if (ph_sum < 0) begin
      ph_clamped = '0;
    end else if (ph_sum > $signed({{(PH_SUM_W-PH_W){1'b0}}, PH_TOP})) begin
      ph_clamped = PH_TOP;
    end else begin
      ph_clamped = ph_sum[PH_W-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ph7_code       <= RST_PH7_CODE;
      slope_per_code <= RST_SLOPE;
      offset_corr    <= RST_OFFSET;
      safe_min       <= RST_SAFE_MIN;
      safe_max       <= RST_SAFE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PH7_CODE: ph7_code       <= cfg_data[SAMPLE_W-1:0];
        REG_SLOPE:    slope_per_code <= $signed(cfg_data[SLOPE_W-1:0]);
        REG_OFFSET:   offset_corr    <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_SAFE_MIN: safe_min       <= cfg_data[PH_W-1:0];
        REG_SAFE_MAX: safe_max       <= cfg_data[PH_W-1:0];
        default: ;    // drop writes to unknown indexes
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      burst_count  <= '0;
      window_index <= '0;
      window_full  <= 1'b0;
      phase_win    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // load a new result when free, else drop valid after a transfer
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_xfer) begin
            if (burst_count == BW'(BURST_SAMPLES - 1)) begin
              // burst complete: search the burst for its median
              burst_count <= '0;
              phase_win   <= 1'b0;
              cand        <= '0;
              state       <= S_LOAD;
            end else begin
              burst_count <= burst_count + 1'b1;
            end
          end
        end
        S_LOAD: begin
          state <= S_CAND;
        end
        S_CAND: begin
          // candidate arrives; the first scan read issues in S_SCAN
          cand_val <= rdata;
          issue    <= '0;
          done_cnt <= '0;
          lt_cnt   <= '0;
          le_cnt   <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          issue <= issue + 1'b1;
          if (issue != '0) begin
            // data of entry done_cnt is on the read port
            if (rdata < cand_val) begin
              lt_cnt <= lt_cnt + 1'b1;
            end
            if (rdata <= cand_val) begin
              le_cnt <= le_cnt + 1'b1;
            end
            done_cnt <= done_cnt + 1'b1;
            if (done_cnt == n_len - 1'b1) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // candidate holds the wanted rank when lt <= k < le
          if (lt_cnt <= k_rank && le_cnt > k_rank) begin
            if (phase_win) begin
              result <= cand_val;
              state  <= S_OUT;
            end else begin
              med   <= cand_val[SAMPLE_W-1:0];
              state <= S_MUL;
            end
          end else begin
            cand  <= cand + 1'b1;
            state <= S_LOAD;
          end
        end
        S_MUL: begin
          product <= PROD_W'(diff) * PROD_W'(slope_per_code);
          state   <= S_CONV;
        end
        S_CONV: begin
          // ring write happens in the memory block this cycle
          result <= ph_clamped;
          if (window_index == WW'(WINDOW - 1)) begin
            window_index <= '0;
            window_full  <= 1'b1;
          end else begin
            window_index <= window_index + 1'b1;
          end
          if (window_full || window_index == WW'(WINDOW - 1)) begin
            phase_win <= 1'b1;
            cand      <= '0;
            state     <= S_LOAD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            m_tdata  <= {{(16-PH_W){1'b0}}, result};
            m_tuser  <= (result >= safe_min) && (result <= safe_max);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/tb_ph_median_calibrated_filter_core.sv @@
// Self-checking testbench for ph_median_calibrated_filter_core: streams ADC bursts,
// tracks the burst median, calibration, clamp and ring median, and checks every result.
// Depends on pmcf_pkg and the core RTL.
module tb_ph_median_calibrated_filter_core;
  import pmcf_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RST_CYCLES    = 6;
  // Two full rank searches plus calibration and output load stay below this.
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES   = 1500;
  localparam int CYCLE_LIMIT   = 400000;

  // Indexes past the last register; writes there must leave the block untouched.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int SLOPE_MIN      = -(1 << (SLOPE_W - 1));
  localparam int SLOPE_MAX      = (1 << (SLOPE_W - 1)) - 1;
  localparam int OFFSET_RAW_MIN = -(1 << (OFFSET_W - 1));

  typedef struct packed {
    logic [15:0] tdata;
    logic        tuser;
  } ph_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;   // [11:0] adc_sample, [15:12] zero
  logic                  m_tvalid;
  logic                  m_tready;
  logic [15:0]           m_tdata;   // [13:0] ph_value, [15:14] zero
  logic                  m_tuser;   // [0] in_safe_range
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Tracked block state: burst memory, pH ring and calibration registers.
  logic [SAMPLE_W-1:0] burst_mem [DEF_BURST_SAMPLES];
  int                  burst_fill;
  int                  ring_mem [DEF_WINDOW];
  int                  ring_pos;
  bit                  ring_wrapped;
  int                  cal_ph7;
  int                  cal_slope;
  int                  cal_offset;
  int                  cal_safe_min;
  int                  cal_safe_max;

  ph_result_t pending_ph[$];
  ph_result_t head_ph;
  int         mismatches;
  int         cycle_count;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_start;
  int hold_left;

  ph_median_calibrated_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Value of rank k (ascending, from zero): the entry with at most k smaller
  // entries and more than k smaller-or-equal ones.
  function automatic int rank_value(input int vals[$], input int k);
    int less;
    int same;
    foreach (vals[i]) begin
      less = 0;
      same = 0;
      foreach (vals[j]) begin
        if (vals[j] < vals[i]) less++;
        else if (vals[j] == vals[i]) same++;
      end
      if (less <= k && k < less + same) return vals[i];
    end
    return 0;
  endfunction

  // Advance the tracked state by one accepted sample; queue a pH result when
  // the sample closes a burst.
  task automatic update_ph_filter(input logic [SAMPLE_W-1:0] sample);
    int         vals[$];
    int         median;
    int         off;
    int         ph;
    int         picked;
    longint     prod;
    ph_result_t res;
    burst_mem[burst_fill] = sample;
    burst_fill++;
    if (burst_fill < DEF_BURST_SAMPLES) return;
    burst_fill = 0;
    foreach (burst_mem[i]) vals.push_back(int'(burst_mem[i]));
    median = rank_value(vals, DEF_BURST_SAMPLES >> 1);
    // Clip the offset at its floor, then scale; >>> on a signed product floors.
    off  = (cal_offset < int'(OFFSET_FLOOR)) ? int'(OFFSET_FLOOR) : cal_offset;
    prod = longint'(cal_ph7 - median) * longint'(cal_slope);
    ph   = int'(PH_SEVEN) + int'(prod >>> SHIFT) + off;
    if (ph < 0) ph = 0;
    if (ph > int'(PH_TOP)) ph = int'(PH_TOP);
    ring_mem[ring_pos] = ph;
    ring_pos++;
    if (ring_pos >= DEF_WINDOW) begin
      ring_pos     = 0;
      ring_wrapped = 1'b1;
    end
    if (ring_wrapped) begin
      vals.delete();
      foreach (ring_mem[i]) vals.push_back(ring_mem[i]);
      picked = rank_value(vals, DEF_WINDOW >> 1);
    end else begin
      picked = ph;
    end
    res.tdata = 16'(picked);
    res.tuser = (picked >= cal_safe_min) && (picked <= cal_safe_max);
    pending_ph.push_back(res);
  endtask

  // Offer one sample after a random idle gap; hold it until the transfer.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= 16'(sample);
    do @(posedge clk); while (!s_tready);
    update_ph_filter(sample);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PH7_CODE: cal_ph7      = int'(data[SAMPLE_W-1:0]);
      REG_SLOPE:    cal_slope    = int'($signed(data[SLOPE_W-1:0]));
      REG_OFFSET:   cal_offset   = int'($signed(data[OFFSET_W-1:0]));
      REG_SAFE_MIN: cal_safe_min = int'(data[PH_W-1:0]);
      REG_SAFE_MAX: cal_safe_max = int'(data[PH_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the input, wait for every queued result, then let the block idle.
  task automatic settle_block();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_ph.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_calibration(input int ph7, input int slope, input int offset,
                                  input int smin, input int smax);
    settle_block();
    write_reg(REG_PH7_CODE, CFG_DATA_W'(ph7));
    write_reg(REG_SLOPE,    CFG_DATA_W'(slope));
    write_reg(REG_OFFSET,   CFG_DATA_W'(offset));
    write_reg(REG_SAFE_MIN, CFG_DATA_W'(smin));
    write_reg(REG_SAFE_MAX, CFG_DATA_W'(smax));
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
              CFG_DATA_W'($urandom));
  endtask

  task automatic random_calibration();
    int ph7;
    int slope;
    int offset;
    int lo;
    int hi;
    int t;
    ph7 = $urandom_range(SAMPLE_MAX);
    case ($urandom_range(3))
      0:       slope = int'($urandom_range(SLOPE_MAX - SLOPE_MIN)) + SLOPE_MIN;
      1:       slope = -int'($urandom_range(12000, 2000));
      default: slope = int'($urandom_range(12000, 2000));
    endcase
    case ($urandom_range(4))
      0:       offset = -int'($urandom_range(-OFFSET_RAW_MIN, 513));
      1:       offset = $urandom_range(int'(PH_TOP));
      default: offset = int'($urandom_range(2048)) - 512;
    endcase
    lo = $urandom_range(int'(PH_TOP));
    hi = $urandom_range(int'(PH_TOP));
    // Keep the safe range ordered most of the time; leave it inverted otherwise.
    if (lo > hi && $urandom_range(3) != 0) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    load_calibration(ph7, slope, offset, lo, hi);
  endtask

  // Mostly samples close to the pH 7 code so the output stays off the rails,
  // with rail values and full-range noise mixed in.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = SAMPLE_MAX;
      2, 3:    v = $urandom_range(SAMPLE_MAX);
      default: v = cal_ph7 + int'($urandom_range(600)) - 300;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic random_samples(input int count);
    repeat (count) send_sample(pick_sample());
  endtask

  // Reset calibration: an all-zero burst saturates high, a full-scale burst
  // gives a negative product, and the mixed burst lands exactly on safe_min.
  task automatic test_directed_bursts();
    logic [SAMPLE_W-1:0] mixed [DEF_BURST_SAMPLES] =
      '{0, 4095, 3102, 1, 4094, 3102, 2048, 3103, 3101};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DEF_BURST_SAMPLES) send_sample('0);
    repeat (DEF_BURST_SAMPLES) send_sample(SAMPLE_W'(SAMPLE_MAX));
    foreach (mixed[i]) send_sample(mixed[i]);
  endtask

  // Register extremes: offset below its floor, output at zero for all but the lowest
  // medians; an inverted safe range with the opposite slope; then a random setting.
  task automatic test_calibration_extremes();
    load_calibration(0, SLOPE_MAX, OFFSET_RAW_MIN, 0, int'(PH_TOP));
    random_samples(90);
    load_calibration(SAMPLE_MAX, SLOPE_MIN, int'(PH_TOP), int'(PH_TOP), 0);
    random_samples(90);
    random_calibration();
    random_samples(90);
  endtask

  task automatic test_idle_phases();
    int send_pct [4] = '{0, 66, 0, 12};
    int recv_pct [4] = '{0, 0, 66, 12};
    foreach (send_pct[p]) begin
      random_calibration();
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      random_samples(180);
    end
  endtask

  // Hold the result side off for a long stretch while bursts keep coming, so
  // the output register and the search engine fill and the input stalls.
  task automatic test_backpressure();
    load_calibration(int'(RST_PH7_CODE), int'(RST_SLOPE), int'(RST_OFFSET),
                     int'(RST_SAFE_MIN), int'(RST_SAFE_MAX));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_start     = 1'b1;
    random_samples(6 * DEF_BURST_SAMPLES);
  endtask

  // Result side: stall at random, or hold off completely when asked.
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest queued pH result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_ph.size() == 0) begin
        $display("%0t: result transfer with none queued, tdata=%0d tuser=%0b",
                 $time, m_tdata, m_tuser);
        mismatches++;
      end else begin
        head_ph = pending_ph.pop_front();
        if (m_tdata !== head_ph.tdata) begin
          $display("%0t: ph_value expected %0d actual %0d",
                   $time, head_ph.tdata, m_tdata);
          mismatches++;
        end
        if (m_tuser !== head_ph.tuser) begin
          $display("%0t: in_safe_range expected %0b actual %0b",
                   $time, head_ph.tuser, m_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still queued", $time, pending_ph.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // Tracked state after reset.
    cal_ph7      = int'(RST_PH7_CODE);
    cal_slope    = int'(RST_SLOPE);
    cal_offset   = int'(RST_OFFSET);
    cal_safe_min = int'(RST_SAFE_MIN);
    cal_safe_max = int'(RST_SAFE_MAX);
    foreach (burst_mem[i]) burst_mem[i] = '0;
    foreach (ring_mem[i]) ring_mem[i] = int'(PH_SEVEN);
    burst_fill     = 0;
    ring_pos       = 0;
    ring_wrapped   = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_start     = 1'b0;
    hold_left      = 0;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_directed_bursts();
    test_calibration_extremes();
    test_idle_phases();
    test_backpressure();

    settle_block();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pmcf_pkg.sv
hw/rtl/ph_median_calibrated_filter_core.sv
tb/sv/tb_ph_median_calibrated_filter_core.sv
